// ----- hw/rtl/prime_sieve_range_macros.svh -----
// ----------------------------------------------------------------------------
// Prime sieve range assertion macros
// Shared property wrappers for the prime sieve range checks.
// ----------------------------------------------------------------------------
`ifndef PRIME_SIEVE_RANGE_MACROS_SVH
`define PRIME_SIEVE_RANGE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/prs_pkg.sv -----
// ----------------------------------------------------------------------------
// Prime sieve range package
// Types and constants shared by the prime sieve range block.
// ----------------------------------------------------------------------------
package prs_pkg;

  localparam logic [7:0] LIMIT      = 8'd255;
  localparam int         MARK_DEPTH = 256;

  typedef struct packed {
    logic [7:0] low_bound;
    logic [7:0] high_bound;
  } prs_in_t;

  typedef struct packed {
    logic [7:0] prime_value;
    logic       last_of_run;
    logic       range_empty;
    logic       range_error;
  } prs_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FACT_RD,
    ST_FACT_CHK,
    ST_CROSS,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FINISH
  } prs_state_t;

endpackage

// ----- hw/rtl/prs_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/prime_sieve_range.sv -----
// ----------------------------------------------------------------------------
// Prime sieve range
// Lists the primes between a low and a high bound with a sieve bitmap.
// ----------------------------------------------------------------------------
// channel  ports                     payload
// in       in_valid / in_ready       prs_in_t  (low_bound, high_bound)
// out      out_valid / out_ready     prs_out_t (prime_value, flags)
//
// One request: clear 0..top, cross out multiples of each unmarked factor,
// scan low..top; all through one bitmap RAM port pair. A rejected request
// skips the sieve and goes straight to the finish state.
// in_ready is high only between requests; out stalls hold the sequencer.
// Synchronous active-low reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module prime_sieve_range
  import prs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  prs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output prs_out_t out_data
);

  prs_state_t state_r, state_nxt;
  logic [7:0] low_r, low_nxt;
  logic [7:0] top_r, top_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [4:0] fac_r, fac_nxt;
  logic [8:0] mul_r, mul_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic       pend_vld_r, pend_vld_nxt;
  logic       err_r, err_nxt;
  logic       out_vld_r, out_vld_nxt;
  prs_out_t   out_r, out_nxt;

  logic       ram_we;
  logic [7:0] ram_waddr;
  logic       ram_wdata;
  logic [7:0] ram_raddr;
  logic       ram_rdata;

  logic [9:0] fac_sq;
  logic [8:0] mul_step;
  logic       out_free;
  logic [7:0] in_top;

  prs_ram #(
    .WIDTH(1),
    .DEPTH(MARK_DEPTH)
  ) u_marks (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign fac_sq   = {5'd0, fac_r} * {5'd0, fac_r};
  assign mul_step = mul_r + {4'd0, fac_r};
  assign out_free = !out_vld_r || out_ready;
  assign in_top   = (in_data.high_bound > LIMIT) ? LIMIT : in_data.high_bound;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r  <= low_nxt;
    top_r  <= top_nxt;
    addr_r <= addr_nxt;
    fac_r  <= fac_nxt;
    mul_r  <= mul_nxt;
    pend_r <= pend_nxt;
    err_r  <= err_nxt;
    out_r  <= out_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    low_nxt      = low_r;
    top_nxt      = top_r;
    addr_nxt     = addr_r;
    fac_nxt      = fac_r;
    mul_nxt      = mul_r;
    pend_nxt     = pend_r;
    pend_vld_nxt = pend_vld_r;
    err_nxt      = err_r;
    out_vld_nxt  = out_vld_r && !out_ready;
    out_nxt      = out_r;
    ram_we       = 1'b0;
    ram_waddr    = addr_r;
    ram_wdata    = 1'b0;
    ram_raddr    = addr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          low_nxt      = in_data.low_bound;
          top_nxt      = in_top;
          addr_nxt     = 8'd0;
          pend_vld_nxt = 1'b0;
          err_nxt      = (in_data.low_bound == 8'd0) ||
                         (in_data.low_bound > in_data.high_bound);
          if (err_nxt || (in_data.low_bound > in_top)) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = addr_r;
        ram_wdata = (addr_r < 8'd2);
        if (addr_r == top_r) begin
          fac_nxt   = 5'd2;
          state_nxt = ST_FACT_RD;
        end else begin
          addr_nxt = addr_r + 8'd1;
        end
      end
      ST_FACT_RD: begin
        ram_raddr = {3'd0, fac_r};
        if (fac_sq > {2'd0, top_r}) begin
          addr_nxt  = low_r;
          state_nxt = ST_SCAN_RD;
        end else begin
          state_nxt = ST_FACT_CHK;
        end
      end
      ST_FACT_CHK: begin
        ram_raddr = {3'd0, fac_r};
        if (ram_rdata) begin
          fac_nxt   = fac_r + 5'd1;
          state_nxt = ST_FACT_RD;
        end else begin
          mul_nxt   = fac_sq[8:0];
          state_nxt = ST_CROSS;
        end
      end
      ST_CROSS: begin
        ram_we    = 1'b1;
        ram_waddr = mul_r[7:0];
        ram_wdata = 1'b1;
        if (mul_step > {1'b0, top_r}) begin
          fac_nxt   = fac_r + 5'd1;
          state_nxt = ST_FACT_RD;
        end else begin
          mul_nxt = mul_step;
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (!ram_rdata && pend_vld_r && !out_free) begin
          state_nxt = ST_SCAN_CHK;
        end else begin
          if (!ram_rdata) begin
            if (pend_vld_r) begin
              out_vld_nxt = 1'b1;
              out_nxt     = '{prime_value: pend_r, last_of_run: 1'b0,
                              range_empty: 1'b0, range_error: 1'b0};
            end
            pend_nxt     = addr_r;
            pend_vld_nxt = 1'b1;
          end
          if (addr_r == top_r) begin
            state_nxt = ST_FINISH;
          end else begin
            addr_nxt  = addr_r + 8'd1;
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          if (err_r) begin
            out_nxt = '{prime_value: 8'd0, last_of_run: 1'b1,
                        range_empty: 1'b0, range_error: 1'b1};
          end else if (pend_vld_r) begin
            out_nxt = '{prime_value: pend_r, last_of_run: 1'b1,
                        range_empty: 1'b0, range_error: 1'b0};
          end else begin
            out_nxt = '{prime_value: 8'd0, last_of_run: 1'b1,
                        range_empty: 1'b1, range_error: 1'b0};
          end
          pend_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/prs_chk.sv -----
// ----------------------------------------------------------------------------
// Prime sieve range checks
// Port-level assertions, bound to the prime sieve range top level.
// ----------------------------------------------------------------------------
`include "prime_sieve_range_macros.svh"

module prs_chk
  import prs_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input prs_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input prs_out_t out_data
);

  `PRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "out request dropped or changed while stalled")
  `PRS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "in_ready high right after a request was taken")
  `PRS_ASSERT_NOW(a_flags_excl, out_valid, !(out_data.range_empty && out_data.range_error), "empty and error flags both set")
  `PRS_ASSERT_NOW(a_flag_item, out_valid && (out_data.range_empty || out_data.range_error), out_data.last_of_run && (out_data.prime_value == 8'd0), "flagged item not last or value not zero")
  `PRS_ASSERT_NOW(a_prime_min, out_valid && !out_data.range_empty && !out_data.range_error, out_data.prime_value >= 8'd2, "reported prime below two")

endmodule

bind prime_sieve_range prs_chk u_prs_chk (.*);

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Prime sieve range testbench
// Sends low/high bound requests through a valid/ready driver and checks every
// reported prime, empty flag and error flag against a local sieve of the
// range. It runs directed corner requests, then random phases with sender
// idling, receiver stalls and long output hold-offs.
// ----------------------------------------------------------------------------
module tb
  import prs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 2500;
  localparam int DRAIN_CYCLES   = 64;
  localparam int MAX_REPORTS    = 10;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  prs_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  prs_out_t out_data;

  prs_in_t  request_q[$];
  prs_out_t expected_primes[$];
  prs_out_t want;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_gen       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int idle_cycles    = 0;
  int mismatch_cnt   = 0;

  prime_sieve_range u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void predict_primes(prs_in_t req);
    bit       composite [0:MARK_DEPTH-1];
    int       top;
    int       f;
    int       m;
    int       n;
    int       last_prime;
    prs_out_t item;
    item = '0;
    if (req.low_bound == 8'd0 || req.low_bound > req.high_bound) begin
      item.last_of_run = 1'b1;
      item.range_error = 1'b1;
      expected_primes.push_back(item);
      return;
    end
    top = (req.high_bound > LIMIT) ? int'(LIMIT) : int'(req.high_bound);
    for (n = 0; n <= top; n++) composite[n] = 1'b0;
    composite[0] = 1'b1;
    composite[1] = 1'b1;
    for (f = 2; f * f <= top; f++) begin
      if (!composite[f]) begin
        for (m = f * f; m <= top; m += f) composite[m] = 1'b1;
      end
    end
    last_prime = -1;
    for (n = top; n >= int'(req.low_bound) && last_prime < 0; n--) begin
      if (!composite[n]) last_prime = n;
    end
    if (last_prime < 0) begin
      item.last_of_run = 1'b1;
      item.range_empty = 1'b1;
      expected_primes.push_back(item);
      return;
    end
    for (n = int'(req.low_bound); n <= last_prime; n++) begin
      if (!composite[n]) begin
        item.prime_value = 8'(n);
        item.last_of_run = (n == last_prime);
        expected_primes.push_back(item);
      end
    end
  endfunction

  function automatic prs_in_t make_request();
    prs_in_t req;
    int      sel;
    int      lo;
    int      hi;
    sel = $urandom_range(99);
    if (sel < 12) begin
      if ($urandom_range(1) == 0) begin
        lo = 0;
        hi = $urandom_range(255);
      end else begin
        hi = $urandom_range(254);
        lo = $urandom_range(255, hi + 1);
      end
    end else if (sel < 27) begin
      lo = $urandom_range(255, 1);
      hi = lo + $urandom_range(6);
      if (hi > 255) hi = 255;
    end else begin
      hi = $urandom_range(255, 1);
      lo = $urandom_range(hi, 1);
    end
    req.low_bound  = 8'(lo);
    req.high_bound = 8'(hi);
    return req;
  endfunction

  task automatic add_request(input int lo, input int hi);
    prs_in_t req;
    req.low_bound  = 8'(lo);
    req.high_bound = 8'(hi);
    request_q.push_back(req);
  endtask

  task automatic wait_drain();
    while (request_q.size() != 0 || in_valid || expected_primes.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_items,
                           input bit with_hold);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n_items) request_q.push_back(make_request());
    if (with_hold) hold_gen++;
    wait_drain();
  endtask

  // drive requests
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_primes(in_data);
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= request_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // stall the result channel
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_gen) begin
      hold_seen <= hold_gen;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // check results
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_primes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("%0t unexpected result: value %0d last %0b empty %0b error %0b", $realtime,
                   out_data.prime_value, out_data.last_of_run, out_data.range_empty,
                   out_data.range_error);
      end else begin
        want = expected_primes.pop_front();
        if (out_data.prime_value !== want.prime_value ||
            out_data.last_of_run !== want.last_of_run ||
            out_data.range_empty !== want.range_empty ||
            out_data.range_error !== want.range_error) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("%0t mismatch: exp %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b", $realtime,
                     want.prime_value, want.last_of_run, want.range_empty,
                     want.range_error, out_data.prime_value, out_data.last_of_run,
                     out_data.range_empty, out_data.range_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    add_request(0, 0);
    add_request(0, 255);
    add_request(5, 3);
    add_request(255, 254);
    add_request(1, 1);
    add_request(2, 2);
    add_request(1, 255);
    add_request(255, 255);
    add_request(251, 255);
    add_request(4, 4);
    add_request(3, 3);
    add_request(1, 2);
    add_request(24, 28);
    add_request(113, 127);
    add_request(121, 121);
    add_request(169, 169);
    add_request(48, 49);
    add_request(128, 128);
    add_request(200, 211);
    add_request(127, 127);
    add_request(1, 3);
    wait_drain();
    run_phase(0, 0, 80, 1'b1);
    run_phase(84, 0, 80, 1'b0);
    run_phase(0, 84, 80, 1'b1);
    run_phase(36, 36, 90, 1'b1);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && expected_primes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
